FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions, sampled on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition implies a consequence at the next clock edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/smaf_pkg.sv
// ----------------------------------------------------------------------------
// smaf_pkg
// Shared types and constants of the sliding median / average filter.
// ----------------------------------------------------------------------------
package smaf_pkg;

  localparam int unsigned MAX_WINDOW  = 20;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned MED_MIN     = 3;
  localparam int unsigned AVG_MIN     = 2;
  localparam int unsigned AVG_MAX     = 20;
  localparam int unsigned WIN_W =
      $clog2(((MAX_WINDOW > AVG_MAX) ? MAX_WINDOW : AVG_MAX) + 1);
  localparam int unsigned ACC_W = SAMPLE_BITS + WIN_W;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned IDX_W = 3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WIN_W-1:0]       win_t;
  typedef logic [ACC_W-1:0]       acc_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_MED_EN  = 3'd0,
    CFG_MED_WIN = 3'd1,
    CFG_AVG_EN  = 3'd2,
    CFG_AVG_WIN = 3'd3,
    CFG_NEAR    = 3'd4,
    CFG_FAR     = 3'd5
  } cfg_idx_e;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic shift;   // take the newer neighbor's sample
    logic load;    // copy sample into the circulating slot, clear ranks
    logic rotate;  // hand the circulating slot to the newer neighbor
    logic count;   // rank own sample against the circulating one
    logic mark;    // flag the cell whose rank is the median
  } cell_ctrl_t;

endpackage

FILE: hdl/smaf_cell.sv
// ----------------------------------------------------------------------------
// smaf_cell
// One ring position: holds a sample, ranks it against a circulating sample.
// ----------------------------------------------------------------------------
module smaf_cell import smaf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       in_win_i,
  input  win_t       rank_i,
  input  sample_t    held_i,
  output sample_t    held_o,
  input  sample_t    circ_i,
  input  logic       tag_i,
  output sample_t    circ_o,
  output logic       tag_o
);

  sample_t held_q;
  sample_t circ_q;
  logic    tag_q;
  win_t    lt_q;
  win_t    le_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      held_q <= held_i;
    end
    if (ctrl_i.load || ctrl_i.mark) begin
      circ_q <= held_q;
    end else if (ctrl_i.rotate) begin
      circ_q <= circ_i;
    end
  end

  // Median cell: fewer than k+1 samples below it, more than k at or below it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= 1'b0;
      lt_q  <= '0;
      le_q  <= '0;
    end else if (ctrl_i.load) begin
      tag_q <= in_win_i;
      lt_q  <= '0;
      le_q  <= '0;
    end else if (ctrl_i.mark) begin
      tag_q <= in_win_i && (lt_q <= rank_i) && (rank_i < le_q);
    end else if (ctrl_i.rotate) begin
      tag_q <= tag_i;
      if (ctrl_i.count && tag_q) begin
        if (circ_q < held_q) begin
          lt_q <= lt_q + 1'b1;
        end
        if (circ_q <= held_q) begin
          le_q <= le_q + 1'b1;
        end
      end
    end
  end

  assign held_o = held_q;
  assign circ_o = circ_q;
  assign tag_o  = tag_q;

endmodule

FILE: hdl/smaf_div.sv
// ----------------------------------------------------------------------------
// smaf_div
// Restoring divider, one quotient bit per cycle, for the window mean.
// ----------------------------------------------------------------------------
module smaf_div import smaf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  acc_t dividend_i,
  input  win_t divisor_i,
  output logic done_o,
  output acc_t quotient_o
);

  localparam int unsigned CNT_W = $clog2(ACC_W);

  acc_t             dq_q;
  logic [WIN_W-1:0] rem_q;
  win_t             div_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q;
  logic             done_q;

  logic [WIN_W:0] rem_sh;
  logic [WIN_W:0] rem_sub;
  logic           ge;

  assign rem_sh  = {rem_q, dq_q[ACC_W-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_q   <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        dq_q  <= dividend_i;
        rem_q <= '0;
        div_q <= divisor_i;
        cnt_q <= CNT_W'(ACC_W - 1);
        run_q <= 1'b1;
      end else if (run_q) begin
        dq_q  <= {dq_q[ACC_W-2:0], ge};
        rem_q <= ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

FILE: hdl/sliding_median_average_filter.sv
// ----------------------------------------------------------------------------
// sliding_median_average_filter
// Distance filter: sliding median or moving average with near/far alarms.
// ----------------------------------------------------------------------------
// Each accepted distance sample yields one result transaction. Samples enter a
// chain of MAX_WINDOW cells, newest in cell 0; the ring length is the larger
// of the enabled windows. Until that many samples have arrived since the last
// filter register write (or when no filter is on) the raw sample passes
// through. Otherwise the samples circulate once round the chain while every
// cell ranks itself: the median then takes one more circulation to pick the
// marked cell; the mean accumulates the sum during the first circulation and
// then runs one quotient bit per cycle through the divider. The input stalls
// while an item is being worked on; a finished result waits in the output
// register, so the next sample can be taken while the previous result is
// still stalled. Config writes to the enable or window registers restart the
// fill; threshold writes do not.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sliding_median_average_filter import smaf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sample_t          distance_sample_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sample_t          filtered_distance_o,
  output logic             near_alarm_o,
  output logic             far_alarm_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned STEP_W = $clog2(MAX_WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_RANK, ST_MARK, ST_PICK, ST_DIVGO, ST_DIV, ST_DONE
  } state_e;

  // Round an even median window up to odd, floor at the minimum
  function automatic win_t med_clamp(input logic [3:0] v);
    logic [3:0] o;
    o = v | 4'd1;
    if (o < 4'(MED_MIN)) o = 4'(MED_MIN);
    return WIN_W'(o);
  endfunction

  function automatic win_t avg_clamp(input logic [4:0] v);
    logic [4:0] o;
    o = v;
    if (o < 5'(AVG_MIN)) o = 5'(AVG_MIN);
    if (o > 5'(AVG_MAX)) o = 5'(AVG_MAX);
    return WIN_W'(o);
  endfunction

  function automatic win_t lim(input win_t w);
    return (w > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : w;
  endfunction

  // ---------------------------------------------------------------- config
  logic    med_en_q, avg_en_q;
  win_t    med_win_q, avg_win_q;
  sample_t near_thr_q, far_thr_q;
  logic    filt_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      med_en_q   <= 1'b0;
      med_win_q  <= WIN_W'(MED_MIN);
      avg_en_q   <= 1'b0;
      avg_win_q  <= WIN_W'(AVG_MIN);
      near_thr_q <= '0;
      far_thr_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MED_EN:  med_en_q   <= cfg_data_i[0];
        CFG_MED_WIN: med_win_q  <= med_clamp(cfg_data_i[3:0]);
        CFG_AVG_EN:  avg_en_q   <= cfg_data_i[0];
        CFG_AVG_WIN: avg_win_q  <= avg_clamp(cfg_data_i[4:0]);
        CFG_NEAR:    near_thr_q <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_FAR:     far_thr_q  <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Any write to an enable or window register restarts the fill
  assign filt_wr = cfg_we_i && ((cfg_idx_i == CFG_MED_EN) || (cfg_idx_i == CFG_MED_WIN) ||
                                (cfg_idx_i == CFG_AVG_EN) || (cfg_idx_i == CFG_AVG_WIN));

  // Effective windows and ring length
  win_t med_n, avg_n, m_len, a_len, ring_len, n_sel, rank_k;
  assign med_n    = lim(med_win_q);
  assign avg_n    = lim(avg_win_q);
  assign m_len    = med_en_q ? med_win_q : '0;
  assign a_len    = avg_en_q ? avg_win_q : '0;
  assign ring_len = lim((m_len > a_len) ? m_len : a_len);
  assign n_sel    = med_en_q ? med_n : avg_n;
  assign rank_k   = n_sel >> 1;

  // ---------------------------------------------------------------- cell chain
  cell_ctrl_t cell_ctrl;
  sample_t    held     [MAX_WINDOW];
  sample_t    held_in  [MAX_WINDOW];
  sample_t    circ     [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] tag;
  logic [MAX_WINDOW-1:0] in_win;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    localparam int unsigned NXT = (i + 1) % MAX_WINDOW;

    if (i == 0) begin : g_head
      assign held_in[i] = distance_sample_i;
    end else begin : g_body
      assign held_in[i] = held[i-1];
    end

    assign in_win[i] = WIN_W'(i) < n_sel;

    smaf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .in_win_i (in_win[i]),
      .rank_i   (rank_k),
      .held_i   (held_in[i]),
      .held_o   (held[i]),
      .circ_i   (circ[NXT]),
      .tag_i    (tag[NXT]),
      .circ_o   (circ[i]),
      .tag_o    (tag[i])
    );
  end

  // ---------------------------------------------------------------- divider
  logic div_start, div_done;
  acc_t div_quot;
  acc_t sum_q, sum_d;

  smaf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (avg_n),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // ---------------------------------------------------------------- control
  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                step_last;
  win_t                fill_cnt_q, fill_cnt_d, fill_next;
  logic                filled_q, filled_d, filled_now;
  sample_t             res_q, res_d;
  logic                pick_found_q, pick_found_d;
  logic                out_valid_q, out_valid_d;
  sample_t             out_dist_q, out_dist_d;
  logic                near_q, near_d, far_q, far_d;
  logic                in_acc;
  logic                pick_end;
  logic                out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign fill_next  = fill_cnt_q + 1'b1;
  assign filled_now = filled_q || (fill_next == ring_len);
  assign step_last  = (step_q == STEP_W'(MAX_WINDOW - 1));
  assign pick_end   = (state_q == ST_PICK) && step_last;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    fill_cnt_d   = fill_cnt_q;
    filled_d     = filled_q;
    res_d        = res_q;
    sum_d        = sum_q;
    pick_found_d = pick_found_q;
    out_valid_d  = out_valid_q;
    out_dist_d   = out_dist_q;
    near_d       = near_q;
    far_d        = far_q;
    cell_ctrl    = '0;
    div_start    = 1'b0;

    // Drop the result once the consumer takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d = distance_sample_i;
          if (ring_len != '0) begin
            cell_ctrl.shift = 1'b1;
            if (!filled_q) begin
              fill_cnt_d = fill_next;
              filled_d   = (fill_next == ring_len);
            end
          end
          // Pass the raw sample until the ring has filled once, or while no filter is on
          state_d = ((ring_len != '0) && filled_now) ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        cell_ctrl.load = 1'b1;
        step_d         = '0;
        sum_d          = '0;
        pick_found_d   = 1'b0;
        state_d        = ST_RANK;
      end
      ST_RANK: begin
        // Cell 0 sees every circulating sample once; sum the window ones
        cell_ctrl.rotate = 1'b1;
        cell_ctrl.count  = 1'b1;
        sum_d  = sum_q + (tag[0] ? ACC_W'(circ[0]) : '0);
        step_d = step_q + 1'b1;
        if (step_last) begin
          state_d = med_en_q ? ST_MARK : ST_DIVGO;
        end
      end
      ST_MARK: begin
        cell_ctrl.mark = 1'b1;
        step_d         = '0;
        state_d        = ST_PICK;
      end
      ST_PICK: begin
        // Hold the value of the marked cell as it passes cell 0
        cell_ctrl.rotate = 1'b1;
        if (tag[0]) begin
          res_d        = circ[0];
          pick_found_d = 1'b1;
        end
        step_d = step_q + 1'b1;
        if (step_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DIVGO: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_d   = div_quot[SAMPLE_BITS-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Advance into the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_dist_d  = res_q;
          near_d      = (near_thr_q != '0) && (res_q <= near_thr_q);
          far_d       = (far_thr_q != '0) && (res_q >= far_thr_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (filt_wr) begin
      fill_cnt_d = '0;
      filled_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      fill_cnt_q   <= '0;
      filled_q     <= 1'b0;
      res_q        <= '0;
      sum_q        <= '0;
      pick_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_dist_q   <= '0;
      near_q       <= 1'b0;
      far_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      fill_cnt_q   <= fill_cnt_d;
      filled_q     <= filled_d;
      res_q        <= res_d;
      sum_q        <= sum_d;
      pick_found_q <= pick_found_d;
      out_valid_q  <= out_valid_d;
      out_dist_q   <= out_dist_d;
      near_q       <= near_d;
      far_q        <= far_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign filtered_distance_o = out_dist_q;
  assign near_alarm_o        = near_q;
  assign far_alarm_o         = far_q;

  // ---------------------------------------------------------------- checks
  `ASSERT_NEXT(a_acc_busy, in_acc, in_stall_o, "accepted sample did not start work")
  `ASSERT_CHK(a_fill_len, filled_q |-> (fill_cnt_q == ring_len), "fill count off ring length")
  `ASSERT_NEXT(a_pick_found, pick_end, pick_found_q, "no median cell marked")
  `ASSERT_CHK(a_div_mean, div_start |-> !med_en_q, "divider started with median on")
  `ASSERT_NEXT(a_out_load, out_load, out_valid_q && (state_q == ST_IDLE), "result not loaded")

endmodule

FILE: tb/smaf_predict_compare.sv
// ----------------------------------------------------------------------------
// smaf_predict_compare
// Predicts filter results and compares them with the block's output channel.
// ----------------------------------------------------------------------------
// Tracks every register write and every accepted sample, keeps its own copy
// of the sample ring, and queues one expected result per accepted sample.
// Each accepted result transaction is checked against the oldest entry.
// ----------------------------------------------------------------------------
module smaf_predict_compare import smaf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  sample_t          distance_sample_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  sample_t          filtered_distance_i,
  input  logic             near_alarm_i,
  input  logic             far_alarm_i,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output int unsigned      pending_o,
  output int unsigned      mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MED_MAX      = 15;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    sample_t distance;
    logic    near;
    logic    far;
  } filter_result_t;

  // Shadow registers, windows already rounded and clamped
  logic       med_en;
  logic [3:0] med_win;
  logic       avg_en;
  logic [4:0] avg_win;
  sample_t    near_thr;
  sample_t    far_thr;

  sample_t     ring [MAX_WINDOW];
  int unsigned wr_ptr;
  logic        filled;

  filter_result_t expected_q [$];
  int unsigned    error_total;

  function automatic void clear_ring();
    foreach (ring[k]) ring[k] = '0;
    wr_ptr = 0;
    filled = 1'b0;
  endfunction

  function automatic void apply_cfg_write(input logic [IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
    logic [4:0] w;
    case (idx)
      CFG_MED_EN: begin
        med_en = data[0];
        clear_ring();
      end
      CFG_MED_WIN: begin
        w = {1'b0, data[3:0]};
        if (!w[0]) w = w + 5'd1;
        if (w < MED_MIN) w = 5'(MED_MIN);
        if (w > MED_MAX) w = 5'(MED_MAX);
        med_win = w[3:0];
        clear_ring();
      end
      CFG_AVG_EN: begin
        avg_en = data[0];
        clear_ring();
      end
      CFG_AVG_WIN: begin
        w = data[4:0];
        if (w < AVG_MIN) w = 5'(AVG_MIN);
        if (w > AVG_MAX) w = 5'(AVG_MAX);
        avg_win = w;
        clear_ring();
      end
      CFG_NEAR: near_thr = data[SAMPLE_BITS-1:0];
      CFG_FAR:  far_thr  = data[SAMPLE_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned ring_len();
    int unsigned m;
    int unsigned a;
    m = med_en ? med_win : 0;
    a = avg_en ? avg_win : 0;
    if (a > m) m = a;
    return (m > MAX_WINDOW) ? MAX_WINDOW : m;
  endfunction

  // i = 0 is the newest sample
  function automatic sample_t nth_newest(input int unsigned i, input int unsigned len);
    return ring[(wr_ptr + len + len - 1 - (i % len)) % len];
  endfunction

  function automatic sample_t window_median(input int unsigned n, input int unsigned len);
    sample_t     sorted [MAX_WINDOW];
    sample_t     v;
    int unsigned j;
    if (n > len) n = len;
    if (n == 0) return '0;
    for (int unsigned i = 0; i < n; i++) begin
      v = nth_newest(i, len);
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[n / 2];
  endfunction

  function automatic sample_t window_mean(input int unsigned n, input int unsigned len);
    longint unsigned sum;
    sum = 0;
    if (n > len) n = len;
    if (n == 0) return '0;
    for (int unsigned i = 0; i < n; i++) sum += nth_newest(i, len);
    return sample_t'(sum / n);
  endfunction

  // Store the sample and work out the result it causes
  function automatic filter_result_t filter_step(input sample_t s);
    int unsigned    len;
    sample_t        r;
    filter_result_t res;
    len = ring_len();
    r   = s;
    if (len > 0) begin
      if (wr_ptr >= len) wr_ptr = 0;
      ring[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % len;
      if (wr_ptr == 0) filled = 1'b1;
      if (filled) begin
        if (med_en) r = window_median(med_win, len);
        else if (avg_en) r = window_mean(avg_win, len);
      end
    end
    res.distance = r;
    res.near     = (near_thr != '0) && (r <= near_thr);
    res.far      = (far_thr != '0) && (r >= far_thr);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filter_result_t want;
    filter_result_t got;
    if (!rst_ni) begin
      med_en   = 1'b0;
      med_win  = 4'(MED_MIN);
      avg_en   = 1'b0;
      avg_win  = 5'(AVG_MIN);
      near_thr = '0;
      far_thr  = '0;
      clear_ring();
      expected_q.delete();
      error_total = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (cfg_we_i) apply_cfg_write(cfg_idx_i, cfg_data_i);
      if (out_valid_i && !out_stall_i) begin
        got = '{distance: filtered_distance_i, near: near_alarm_i, far: far_alarm_i};
        if (expected_q.size() == 0) begin
          error_total++;
          if (error_total <= REPORT_LIMIT)
            $display("%t: unexpected result dist=%0d near=%b far=%b",
                     $realtime, got.distance, got.near, got.far);
        end else begin
          want = expected_q.pop_front();
          if (got.distance !== want.distance || got.near !== want.near ||
              got.far !== want.far) begin
            error_total++;
            if (error_total <= REPORT_LIMIT)
              $display("%t: mismatch expected dist=%0d near=%b far=%b, got dist=%0d near=%b far=%b",
                       $realtime, want.distance, want.near, want.far,
                       got.distance, got.near, got.far);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(filter_step(distance_sample_i));
      pending_o        <= expected_q.size();
      mismatch_count_o <= error_total;
    end
  end

endmodule

FILE: tb/tb_sliding_median_average_filter.sv
// ----------------------------------------------------------------------------
// tb_sliding_median_average_filter
// Stimulus and verdict for the sliding median / moving average filter.
// ----------------------------------------------------------------------------
// A short directed part walks through pass-through, the alarms, the median,
// the mean, both filters together, window rounding and clamping, and writes
// to unmapped register indexes. Then random phases reprogram the filter while
// it is idle and stream clustered, uniform, extreme or paired samples, with
// random idle bursts on the input and random stall bursts on the output. A
// separate predictor watches both channels and reports mismatches back here.
// ----------------------------------------------------------------------------
module tb_sliding_median_average_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import smaf_pkg::*;

  localparam int unsigned NUM_ITEMS      = 1200;
  localparam int unsigned QUIET_TAIL     = 150;   // last items run without idling
  localparam int unsigned WATCHDOG_LIMIT = 5000;  // cycles with no transaction at all
  localparam int unsigned DRAIN_CYCLES   = 60;    // about one median pass and then some

  // Register indexes the block does not map
  localparam logic [IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef enum int unsigned {
    MIX_UNIFORM,  // any 16-bit value
    MIX_CLUSTER,  // around a center, within a spread
    MIX_EXTREME,  // values at both ends of the range
    MIX_PAIR      // two neighboring values, many ties
  } sample_mix_e;

  logic             clk_i             = 1'b0;
  logic             rst_ni            = 1'b0;
  logic             in_valid_i        = 1'b0;
  sample_t          distance_sample_i = '0;
  logic             out_stall_i       = 1'b0;
  logic             cfg_we_i          = 1'b0;
  logic [IDX_W-1:0] cfg_idx_i         = '0;
  logic [CFG_W-1:0] cfg_data_i        = '0;

  logic    in_stall_o;
  logic    out_valid_o;
  sample_t filtered_distance_o;
  logic    near_alarm_o;
  logic    far_alarm_o;

  int unsigned pending_results;
  int unsigned mismatch_count;
  int unsigned items_sent   = 0;
  int unsigned stuck_cycles = 0;
  bit          idle_allowed = 1'b1;

  always #2 clk_i = ~clk_i;

  sliding_median_average_filter dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .distance_sample_i   (distance_sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .filtered_distance_o (filtered_distance_o),
    .near_alarm_o        (near_alarm_o),
    .far_alarm_o         (far_alarm_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i)
  );

  smaf_predict_compare result_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .distance_sample_i   (distance_sample_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .filtered_distance_i (filtered_distance_o),
    .near_alarm_i        (near_alarm_o),
    .far_alarm_i         (far_alarm_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .pending_o           (pending_results),
    .mismatch_count_o    (mismatch_count)
  );

  // Watchdog: any accepted transaction or register write counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sliding_median_average_filter: done, errors");
      $finish;
    end
  end

  // Output side: stall in bursts of random length, always reopening in between.
  // No new stall burst starts while idling is switched off.
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (idle_allowed && $urandom_range(7, 0) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(19, 1)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  function automatic sample_t clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return sample_t'(v);
  endfunction

  function automatic sample_t pick_sample(input sample_mix_e mix, input int unsigned center,
                                          input int unsigned spread);
    int v;
    case (mix)
      MIX_UNIFORM: return sample_t'($urandom);
      MIX_CLUSTER: v = int'(center) + int'($urandom_range(2 * spread, 0)) - int'(spread);
      MIX_EXTREME: begin
        case ($urandom_range(3, 0))
          0:       return '0;
          1:       return '1;
          2:       return sample_t'(1);
          default: return '1 - sample_t'(1);
        endcase
      end
      default:     v = int'(center) + int'($urandom_range(1, 0));
    endcase
    return clamp_sample(v);
  endfunction

  // Thresholds: disabled, extreme, random, or close to where the samples fall
  function automatic logic [CFG_W-1:0] pick_threshold(input int unsigned center,
                                                      input int unsigned spread);
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return '1;
      2:       return CFG_W'(1);
      3:       return CFG_W'($urandom);
      default: return clamp_sample(int'(center) + int'($urandom_range(2 * spread, 0))
                                   - int'(spread));
    endcase
  endfunction

  // Median window word: low nibble mostly at the rounding and clamping edges
  function automatic logic [CFG_W-1:0] pick_med_window();
    logic [CFG_W-1:0] w;
    w = CFG_W'($urandom);
    case ($urandom_range(6, 0))
      0: w[3:0] = 4'd0;
      1: w[3:0] = 4'd1;
      2: w[3:0] = 4'd2;
      3: w[3:0] = 4'd14;
      4: w[3:0] = 4'd15;
      default: ;
    endcase
    return w;
  endfunction

  // Average window word: low five bits mostly at the clamping edges
  function automatic logic [CFG_W-1:0] pick_avg_window();
    logic [CFG_W-1:0] w;
    w = CFG_W'($urandom);
    case ($urandom_range(7, 0))
      0: w[4:0] = 5'd0;
      1: w[4:0] = 5'd1;
      2: w[4:0] = 5'd2;
      3: w[4:0] = 5'd20;
      4: w[4:0] = 5'd21;
      5: w[4:0] = 5'd31;
      default: ;
    endcase
    return w;
  endfunction

  // Present a write at the next edge and leave the enable up; a run of writes
  // lands on consecutive edges and close_writes drops the enable afterward.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
  endtask

  task automatic close_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one sample, optionally after an idle burst, and hold it until the
  // transaction is taken. Returns at the edge that accepted it.
  task automatic send_sample(input sample_t v);
    if (idle_allowed && $urandom_range(5, 0) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    distance_sample_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until every expected result has come back. The count
  // from the predictor already includes the edge this is called at.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  // One random phase: reprogram while idle, then stream samples. Now and then
  // rewrite only the thresholds halfway, which must leave the ring alone.
  task automatic run_phase(input int unsigned count);
    sample_mix_e mix;
    int unsigned center;
    int unsigned spread;
    bit          mid_thresholds;
    drain_results();
    idle_allowed = (items_sent + count + QUIET_TAIL <= NUM_ITEMS) &&
                   ($urandom_range(3, 0) != 0);
    center = $urandom_range(65535, 0);
    spread = $urandom_range(1, 0) ? $urandom_range(64, 1) : $urandom_range(4000, 1);
    mix    = sample_mix_e'($urandom_range(3, 0));
    mid_thresholds = ($urandom_range(2, 0) == 0);

    if ($urandom_range(2, 0) != 0) write_reg(CFG_MED_EN, CFG_W'($urandom));
    if ($urandom_range(2, 0) != 0) write_reg(CFG_MED_WIN, pick_med_window());
    if ($urandom_range(2, 0) != 0) write_reg(CFG_AVG_EN, CFG_W'($urandom));
    if ($urandom_range(2, 0) != 0) write_reg(CFG_AVG_WIN, pick_avg_window());
    if ($urandom_range(2, 0) != 0) write_reg(CFG_NEAR, pick_threshold(center, spread));
    if ($urandom_range(2, 0) != 0) write_reg(CFG_FAR, pick_threshold(center, spread));
    if ($urandom_range(5, 0) == 0)
      write_reg($urandom_range(1, 0) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom));
    close_writes();

    for (int unsigned i = 0; i < count; i++) begin
      if (mid_thresholds && i == count / 2) begin
        drain_results();
        write_reg(CFG_NEAR, pick_threshold(center, spread));
        write_reg(CFG_FAR, pick_threshold(center, spread));
        close_writes();
      end
      send_sample(pick_sample(mix, center, spread));
    end
    items_sent += count;
  endtask

  initial begin
    // Hold reset low from the start, then release it on an edge.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: no filter, alarms off, raw samples pass through.
    send_sample('0);
    send_sample('1);

    // Alarms on, both at and next to the thresholds; unmapped index ignored.
    drain_results();
    write_reg(CFG_NEAR, CFG_W'(1000));
    write_reg(CFG_FAR, CFG_W'(50000));
    write_reg(CFG_SPARE_A, '1);
    close_writes();
    send_sample(sample_t'(1000));
    send_sample(sample_t'(50000));
    send_sample(sample_t'(1001));

    // Median with window zero: rounds up to three. Raw until the ring fills.
    drain_results();
    write_reg(CFG_MED_EN, CFG_W'(1));
    write_reg(CFG_MED_WIN, '0);
    close_writes();
    send_sample('1);
    send_sample('0);
    send_sample('1);
    send_sample('0);
    send_sample(sample_t'(7));

    // Mean only, window one clamps to two; full-scale sum checks carry width.
    drain_results();
    write_reg(CFG_MED_EN, CFG_W'(16'hFFFE));
    write_reg(CFG_AVG_EN, CFG_W'(1));
    write_reg(CFG_AVG_WIN, CFG_W'(16'hFFE1));
    write_reg(CFG_NEAR, '1);
    write_reg(CFG_FAR, '0);
    close_writes();
    send_sample('1);
    send_sample('1);
    send_sample(sample_t'(1));
    send_sample('0);

    // Both filters: median wins; even window four rounds up to five.
    drain_results();
    write_reg(CFG_MED_EN, CFG_W'(1));
    write_reg(CFG_MED_WIN, CFG_W'(4));
    write_reg(CFG_AVG_WIN, '0);
    write_reg(CFG_NEAR, CFG_W'(3));
    write_reg(CFG_FAR, CFG_W'(10));
    close_writes();
    send_sample(sample_t'(10));
    send_sample('1);
    send_sample(sample_t'(3));
    send_sample(sample_t'(3));
    send_sample('0);
    send_sample(sample_t'(9));

    // Random phases; most are short, a few long enough to fill a wide ring
    // many times over.
    while (items_sent < NUM_ITEMS) begin
      run_phase(($urandom_range(7, 0) == 0) ? $urandom_range(90, 40) : $urandom_range(30, 6));
    end

    drain_results();
    idle_allowed = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb_sliding_median_average_filter: done, clean");
    end else begin
      $display("tb_sliding_median_average_filter: done, errors");
    end
    $finish;
  end

endmodule
